>>> hdl/bmh_pkg.sv
// Shared types and constants for the binary max-heap priority queue.
// Holds sizes, operation and status codes, and the controller/datapath
// command and status structs. No dependencies.
`default_nettype none

package bmh_pkg;

  localparam int DEPTH      = 1024;
  localparam int KEY_BITS   = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int KIND_W     = 3;
  localparam int STATUS_W   = 2;
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

  typedef enum logic [KIND_W-1:0] {
    K_INSERT       = 3'd0,
    K_REMOVE_FIRST = 3'd1,
    K_REMOVE_AT    = 3'd2,
    K_APPEND_RAW   = 3'd3,
    K_BUILD        = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    RS_POS, RS_CNT, RS_PARENT, RS_LEFT, RS_RIGHT, RS_BLD
  } rd_sel_t;

  typedef enum logic [2:0] {
    PS_KEEP, PS_CNT, PS_PARENT, PS_CHILD, PS_BLD
  } pos_sel_t;

  typedef enum logic {
    KS_KEEP, KS_RD
  } key_sel_t;

  typedef enum logic {
    WA_POS, WA_CNT
  } wa_sel_t;

  typedef enum logic [1:0] {
    WD_KEY, WD_RD, WD_CHILD
  } wd_sel_t;

  typedef struct packed {
    logic     ld_in;
    logic     rd_en;
    rd_sel_t  rd_sel;
    logic     wr_en;
    wa_sel_t  wa_sel;
    wd_sel_t  wd_sel;
    pos_sel_t pos_sel;
    key_sel_t key_sel;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     ld_removed;
    logic     ld_left;
    logic     ld_right;
    logic     bld_init;
    logic     bld_dec;
    logic     st_ld;
    status_t  st_code;
    logic     ld_out;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              full;
    logic              empty;
    logic              bad_pos;
    logic              pos_last;
    logic              pos_zero;
    logic              up_gt;
    logic              dn_more;
    logic              has_right;
    logic              key_gt_child;
    logic              bld_zero;
    logic              half_zero;
  } sts_t;

endpackage

`default_nettype wire

>>> hdl/bmh_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bmh_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/bmh_dp.sv
// Datapath of the heap queue: heap store, count, capacity, sift registers
// and result registers. Depends on bmh_pkg and bmh_ram.
`default_nettype none

module bmh_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bmh_pkg::cmd_t                   cmd,
  input  wire logic [bmh_pkg::KIND_W-1:0]      in_kind,
  input  wire logic [bmh_pkg::KEY_BITS-1:0]    in_key,
  input  wire logic [bmh_pkg::ADDR_W-1:0]      in_position,
  input  wire logic                            cfg_we,
  input  wire logic [bmh_pkg::CNT_W-1:0]       cfg_data,
  output bmh_pkg::sts_t                        sts,
  output logic      [bmh_pkg::KEY_BITS-1:0]    out_removed_key,
  output logic      [bmh_pkg::STATUS_W-1:0]    out_status,
  output logic      [bmh_pkg::CNT_W-1:0]       out_count
);
  import bmh_pkg::*;

  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    cap_r;
  logic [KIND_W-1:0]   kind_r;
  logic [KEY_BITS-1:0] key_r;
  logic [ADDR_W-1:0]   pos_r;
  logic [KEY_BITS-1:0] child_r;
  logic [ADDR_W-1:0]   cidx_r;
  logic [ADDR_W-1:0]   bld_r;
  logic [KEY_BITS-1:0] removed_r;
  status_t             status_r;
  logic [KEY_BITS-1:0] out_key_r;
  status_t             out_st_r;
  logic [CNT_W-1:0]    out_cnt_r;

  logic [CNT_W-1:0]    room;
  logic [CNT_W-1:0]    left_w;
  logic [CNT_W-1:0]    right_w;
  logic [ADDR_W-1:0]   parent;
  logic [ADDR_W-1:0]   half;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic [KEY_BITS-1:0] wr_data;
  logic [KEY_BITS-1:0] rd_data;

  assign room    = (cap_r < CNT_W'(DEPTH)) ? cap_r : CNT_W'(DEPTH);
  assign left_w  = {pos_r, 1'b1};
  assign right_w = {pos_r, 1'b0} + CNT_W'(2);
  assign parent  = (pos_r - ADDR_W'(1)) >> 1;
  assign half    = cnt_r[CNT_W-1:1];

  always_comb begin
    unique case (cmd.rd_sel)
      RS_POS:    rd_addr = pos_r;
      RS_CNT:    rd_addr = cnt_r[ADDR_W-1:0];
      RS_PARENT: rd_addr = parent;
      RS_LEFT:   rd_addr = left_w[ADDR_W-1:0];
      RS_RIGHT:  rd_addr = right_w[ADDR_W-1:0];
      RS_BLD:    rd_addr = bld_r;
      default:   rd_addr = pos_r;
    endcase
    unique case (cmd.wd_sel)
      WD_KEY:   wr_data = key_r;
      WD_RD:    wr_data = rd_data;
      WD_CHILD: wr_data = child_r;
      default:  wr_data = key_r;
    endcase
    wr_addr = (cmd.wa_sel == WA_CNT) ? cnt_r[ADDR_W-1:0] : pos_r;
  end

  bmh_ram #(.W(KEY_BITS), .D(DEPTH)) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      cap_r <= CAP_RESET;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      kind_r    <= in_kind;
      key_r     <= in_key;
      pos_r     <= (in_kind == K_REMOVE_FIRST) ? '0 : in_position;
      removed_r <= '0;
      status_r  <= ST_OK;
    end else begin
      if (cmd.key_sel == KS_RD) begin
        key_r <= rd_data;
      end
      unique case (cmd.pos_sel)
        PS_KEEP:   pos_r <= pos_r;
        PS_CNT:    pos_r <= cnt_r[ADDR_W-1:0];
        PS_PARENT: pos_r <= parent;
        PS_CHILD:  pos_r <= cidx_r;
        PS_BLD:    pos_r <= bld_r;
        default:   pos_r <= pos_r;
      endcase
      if (cmd.ld_removed) begin
        removed_r <= rd_data;
      end
      if (cmd.st_ld) begin
        status_r <= cmd.st_code;
      end
    end
    if (cmd.ld_left) begin
      child_r <= rd_data;
      cidx_r  <= left_w[ADDR_W-1:0];
    end else if (cmd.ld_right && (rd_data > child_r)) begin
      child_r <= rd_data;
      cidx_r  <= right_w[ADDR_W-1:0];
    end
    if (cmd.bld_init) begin
      bld_r <= half - ADDR_W'(1);
    end else if (cmd.bld_dec) begin
      bld_r <= bld_r - ADDR_W'(1);
    end
    if (cmd.ld_out) begin
      out_key_r <= removed_r;
      out_st_r  <= status_r;
      out_cnt_r <= cnt_r;
    end
  end

  always_comb begin
    sts.kind         = kind_r;
    sts.full         = (cnt_r >= room);
    sts.empty        = (cnt_r == '0);
    sts.bad_pos      = ({1'b0, pos_r} >= cnt_r);
    sts.pos_last     = ({1'b0, pos_r} == cnt_r);
    sts.pos_zero     = (pos_r == '0);
    sts.up_gt        = (key_r > rd_data);
    sts.dn_more      = (pos_r < half);
    sts.has_right    = (right_w < cnt_r);
    sts.key_gt_child = (key_r > child_r);
    sts.bld_zero     = (bld_r == '0);
    sts.half_zero    = (half == '0);
  end

  assign out_removed_key = out_key_r;
  assign out_status      = out_st_r;
  assign out_count       = out_cnt_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_wr_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_en && (cmd.wa_sel == WA_POS)) |-> ({1'b0, pos_r} < cnt_r))
    else $error("sift write outside live entries");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.cnt_inc && !cmd.cnt_dec) |=> $stable(cnt_r))
    else $error("entry count moved without command");

endmodule

`default_nettype wire

>>> hdl/bmh_ctrl.sv
// Controller of the heap queue: one-hot state machine sequencing decode,
// sift-up, sift-down, build and result hand-off. Depends on bmh_pkg.
`default_nettype none

module bmh_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          out_stall,
  input  wire bmh_pkg::sts_t sts,
  output bmh_pkg::cmd_t      cmd,
  output logic               in_stall,
  output logic               out_valid
);
  import bmh_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DISP   = 13'b0000000000010,
    S_RM_D0  = 13'b0000000000100,
    S_RM_D1  = 13'b0000000001000,
    S_UP_CHK = 13'b0000000010000,
    S_UP_CMP = 13'b0000000100000,
    S_DN_CHK = 13'b0000001000000,
    S_DN_L   = 13'b0000010000000,
    S_DN_R   = 13'b0000100000000,
    S_DN_CMP = 13'b0001000000000,
    S_BLD_RD = 13'b0010000000000,
    S_BLD_LD = 13'b0100000000000,
    S_FIN    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   is_insert;
  logic   is_build;

  assign out_free  = !out_valid_r || !out_stall;
  assign is_insert = (sts.kind == K_INSERT);
  assign is_build  = (sts.kind == K_BUILD);

  always_comb begin
    cmd         = '0;
    cmd.rd_sel  = RS_POS;
    cmd.wa_sel  = WA_POS;
    cmd.wd_sel  = WD_KEY;
    cmd.pos_sel = PS_KEEP;
    cmd.key_sel = KS_KEEP;
    cmd.st_code = ST_OK;
    state_nxt   = state_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_FIN;
        if (sts.kind == K_INSERT) begin
          if (sts.full) begin
            cmd.st_ld   = 1'b1;
            cmd.st_code = ST_FULL;
          end else begin
            cmd.pos_sel = PS_CNT;
            cmd.cnt_inc = 1'b1;
            state_nxt   = S_UP_CHK;
          end
        end else if (sts.kind == K_APPEND_RAW) begin
          if (sts.full) begin
            cmd.st_ld   = 1'b1;
            cmd.st_code = ST_FULL;
          end else begin
            cmd.wr_en   = 1'b1;
            cmd.wa_sel  = WA_CNT;
            cmd.cnt_inc = 1'b1;
          end
        end else if (sts.kind == K_REMOVE_FIRST) begin
          if (sts.empty) begin
            cmd.st_ld   = 1'b1;
            cmd.st_code = ST_EMPTY;
          end else begin
            cmd.cnt_dec = 1'b1;
            cmd.rd_en   = 1'b1;
            state_nxt   = S_RM_D0;
          end
        end else if (sts.kind == K_REMOVE_AT) begin
          if (sts.bad_pos) begin
            cmd.st_ld   = 1'b1;
            cmd.st_code = ST_RANGE;
          end else begin
            cmd.cnt_dec = 1'b1;
            cmd.rd_en   = 1'b1;
            state_nxt   = S_RM_D0;
          end
        end else if (sts.kind == K_BUILD) begin
          if (!sts.half_zero) begin
            cmd.bld_init = 1'b1;
            state_nxt    = S_BLD_RD;
          end
        end
      end
      S_RM_D0: begin
        cmd.ld_removed = 1'b1;
        if (sts.pos_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RS_CNT;
          state_nxt  = S_RM_D1;
        end
      end
      S_RM_D1: begin
        cmd.key_sel = KS_RD;
        state_nxt   = S_UP_CHK;
      end
      S_UP_CHK: begin
        if (!sts.pos_zero) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RS_PARENT;
          state_nxt  = S_UP_CMP;
        end else if (is_insert) begin
          cmd.wr_en = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_DN_CHK;
        end
      end
      S_UP_CMP: begin
        if (sts.up_gt) begin
          cmd.wr_en   = 1'b1;
          cmd.wd_sel  = WD_RD;
          cmd.pos_sel = PS_PARENT;
          state_nxt   = S_UP_CHK;
        end else if (is_insert) begin
          cmd.wr_en = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_DN_CHK;
        end
      end
      S_DN_CHK: begin
        if (sts.dn_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RS_LEFT;
          state_nxt  = S_DN_L;
        end else begin
          cmd.wr_en = 1'b1;
          if (is_build && !sts.bld_zero) begin
            cmd.bld_dec = 1'b1;
            state_nxt   = S_BLD_RD;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_DN_L: begin
        cmd.ld_left = 1'b1;
        if (sts.has_right) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RS_RIGHT;
          state_nxt  = S_DN_R;
        end else begin
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_R: begin
        cmd.ld_right = 1'b1;
        state_nxt    = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.key_gt_child) begin
          if (is_build && !sts.bld_zero) begin
            cmd.bld_dec = 1'b1;
            state_nxt   = S_BLD_RD;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          cmd.wd_sel  = WD_CHILD;
          cmd.pos_sel = PS_CHILD;
          state_nxt   = S_DN_CHK;
        end
      end
      S_BLD_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = RS_BLD;
        cmd.pos_sel = PS_BLD;
        state_nxt   = S_BLD_LD;
      end
      S_BLD_LD: begin
        cmd.key_sel = KS_RD;
        state_nxt   = S_DN_CHK;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.ld_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd_en && cmd.wr_en))
    else $error("heap store read and write in one cycle");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while stalled");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.ld_out))
    else $error("result valid without load");

endmodule

`default_nettype wire

>>> hdl/binary_max_heap_priority_queue_unit.sv
// Binary max-heap priority queue, 1024 entries of 32-bit keys.
// Channels: in_* carries one operation item (kind, key, position), out_* one
// result item (removed_key, status, count); both use valid/stall, an item
// moves on a clock edge with valid high and stall low. cfg_* writes the
// capacity limit with valid/ready; write it only while the queue is idle.
// Items are processed one at a time. Insert sifts the new key up; remove
// takes the last entry into the freed slot unless it was the last slot, sifts
// it up, then down; build sifts down each interior slot from the last one.
// Append raw, errors, unused kinds and build on fewer than two entries finish
// without a sift. A sift-up level costs one read of the single-read-port heap
// store plus a compare; a sift-down level reads the left child and, if
// present, the right child before the compare.
// The controller returns to idle in the same cycle that out_valid rises, so
// the next item can already be accepted while out_valid is first high.
// The result sits in an output register; the next item is taken while it
// waits, and the queue holds in its final state while an earlier result
// still waits with out_stall high.
// Reset (synchronous, rst_n low) empties the queue and sets the capacity
// limit to 1024; heap store contents are not cleared.
// Depends on bmh_pkg, bmh_ctrl, bmh_dp and bmh_ram.
`default_nettype none

module binary_max_heap_priority_queue_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [bmh_pkg::KIND_W-1:0]      in_kind,
  input  wire logic [bmh_pkg::KEY_BITS-1:0]    in_key,
  input  wire logic [bmh_pkg::ADDR_W-1:0]      in_position,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [bmh_pkg::KEY_BITS-1:0]    out_removed_key,
  output logic      [bmh_pkg::STATUS_W-1:0]    out_status,
  output logic      [bmh_pkg::CNT_W-1:0]       out_count,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bmh_pkg::CNT_W-1:0]       cfg_data
);
  import bmh_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = rst_n;

  bmh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  bmh_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_kind         (in_kind),
    .in_key          (in_key),
    .in_position     (in_position),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .sts             (sts),
    .out_removed_key (out_removed_key),
    .out_status      (out_status),
    .out_count       (out_count)
  );

endmodule

`default_nettype wire
